// ===== rtl/core/fts_pkg.sv =====
// Package for the FLV tag stream splitter.
// Holds the transaction structs, the parse phase and unit kind codes, and the
// FLV framing constants. No dependencies.
package fts_pkg;

    localparam int unsigned POS_W = 25;
    localparam int unsigned LEN_W = 24;

    localparam logic [POS_W-1:0] HDR_LEN     = POS_W'(9);
    localparam logic [POS_W-1:0] HDR_SKIP    = POS_W'(4);
    localparam logic [POS_W-1:0] TAG_HDR     = POS_W'(11);
    localparam logic [POS_W-1:0] TRAILER_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] LEN_BYTES   = POS_W'(3);

    localparam logic [7:0] TYPE_AUDIO  = 8'd8;
    localparam logic [7:0] TYPE_VIDEO  = 8'd9;
    localparam logic [7:0] TYPE_SCRIPT = 8'd18;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_MEDIA  = 4'b0100,
        PH_ERROR  = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        K_HEADER  = 3'd0,
        K_META    = 3'd1,
        K_MEDIA   = 3'd2,
        K_TRAILER = 3'd3,
        K_NONE    = 3'd4
    } t_kind;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_SEEK = 1'b1
    } t_req;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] unit_kind;
        logic       unit_start;
        logic       unit_end;
        logic       error_flag;
    } t_out_item;

endpackage

// ===== rtl/core/flv_tag_stream_splitter.sv =====
// Top level of the FLV tag stream splitter.
// Depends on fts_pkg, fts_in_reg, fts_parser and fts_out_reg.
//
// This block takes an FLV byte stream one transaction per byte and returns
// one labeled transaction for every byte it accepts: the byte itself, the
// kind of unit it belongs to (file header, metadata tag, media tag, trailer,
// or dropped), first/last-byte markers for headers and tags, and an error
// flag on an invalid first tag type. A seek transaction discards any partial
// tag and restarts parsing at a media tag boundary; after an error every
// byte is dropped until a seek or reset. Throughput is one transaction per
// clock, sustained, as long as the result side keeps taking results. A byte
// accepted into the input register is parsed out of it, and its label is
// loaded into the result register, which drives the result port. The
// per-byte work (a few 25-bit adds and compares against the tag length)
// sits between the input register and the result register, which also
// decouples the two handshakes in part: a waiting result does not block the
// next input byte from being registered while the input register is empty.
module flv_tag_stream_splitter import fts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      w_stage_valid;
    t_in_item  w_stage_item;
    logic      w_out_free;
    logic      w_fire;
    t_out_item w_result;

    // A transaction moves from the input register into the parser (and its
    // label into the result register) whenever the result register has room.
    assign w_fire = w_stage_valid && w_out_free;

    fts_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_take  (w_out_free),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item)
    );

    // The parser only advances its state on a firing transaction.
    fts_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_stage_item),
        .o_result (w_result)
    );

    fts_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_out_data)
    );

endmodule

// ===== rtl/core/fts_in_reg.sv =====
// Input register stage of the FLV tag stream splitter.
// Depends on fts_pkg for the input transaction struct.
module fts_in_reg import fts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;
    logic     w_advance;

    // The stage may refill in the same cycle it hands its transaction on.
    assign w_advance = r_valid && i_take;
    assign o_ready   = !r_valid || i_take;
    assign w_accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/fts_parser.sv =====
// Parse state and byte labeling logic of the FLV tag stream splitter.
// Depends on fts_pkg for phases, kinds, constants and transaction structs.
module fts_parser import fts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_meta;
    logic             n_meta;

    logic [7:0]       w_byte;
    logic [LEN_W-1:0] w_len_eff;
    logic [POS_W-1:0] w_tag_last;
    logic [POS_W-1:0] w_pos_inc;
    t_out_item        w_res;

    assign w_byte    = i_item.data_byte;
    assign w_pos_inc = r_pos + POS_W'(1);

    // Length bytes shift in big-endian while the position is inside the
    // three length bytes; the freshly merged value already governs this byte.
    assign w_len_eff  = (r_pos <= LEN_BYTES) ? {r_len[LEN_W-9:0], w_byte} : r_len;
    assign w_tag_last = POS_W'(w_len_eff) + TAG_HDR - POS_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_meta  = r_meta;

        w_res.out_byte   = w_byte;
        w_res.unit_kind  = K_NONE;
        w_res.unit_start = 1'b0;
        w_res.unit_end   = 1'b0;
        w_res.error_flag = 1'b0;

        if (i_item.req_type == REQ_SEEK) begin
            n_phase        = PH_MEDIA;
            n_pos          = '0;
            n_len          = '0;
            n_meta         = 1'b0;
            w_res.out_byte = 8'd0;
        end else begin
            unique case (r_phase)
                PH_ERROR: begin
                    // Dropped: the defaults already say so.
                end
                PH_HEADER: begin
                    if (r_pos < HDR_LEN) begin
                        w_res.unit_kind  = K_HEADER;
                        w_res.unit_start = (r_pos == '0);
                        w_res.unit_end   = (r_pos == HDR_LEN - POS_W'(1));
                        n_pos            = w_pos_inc;
                    end else begin
                        w_res.unit_kind = K_TRAILER;
                        if (r_pos >= HDR_LEN + HDR_SKIP - POS_W'(1)) begin
                            n_phase = PH_FIRST;
                            n_pos   = '0;
                        end else begin
                            n_pos = w_pos_inc;
                        end
                    end
                end
                PH_FIRST, PH_MEDIA: begin
                    if (r_pos == '0) begin
                        n_len = '0;
                        if (r_phase == PH_FIRST && w_byte != TYPE_SCRIPT &&
                            w_byte != TYPE_AUDIO && w_byte != TYPE_VIDEO) begin
                            n_phase          = PH_ERROR;
                            w_res.error_flag = 1'b1;
                        end else begin
                            if (r_phase == PH_FIRST && w_byte == TYPE_SCRIPT) begin
                                n_meta = 1'b1;
                            end else begin
                                n_meta  = 1'b0;
                                n_phase = PH_MEDIA;
                            end
                            w_res.unit_kind  = (n_meta) ? K_META : K_MEDIA;
                            w_res.unit_start = 1'b1;
                            n_pos            = POS_W'(1);
                        end
                    end else begin
                        n_len = w_len_eff;
                        if (r_pos <= w_tag_last) begin
                            w_res.unit_kind = (r_meta) ? K_META : K_MEDIA;
                            w_res.unit_end  = (r_pos == w_tag_last);
                            n_pos           = w_pos_inc;
                        end else begin
                            w_res.unit_kind = K_TRAILER;
                            if (r_pos >= w_tag_last + TRAILER_LEN) begin
                                n_pos   = '0;
                                n_phase = PH_MEDIA;
                            end else begin
                                n_pos = w_pos_inc;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_len   <= '0;
            r_meta  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_meta  <= n_meta;
        end
    end

    assign o_result = w_res;

endmodule

// ===== rtl/core/fts_out_reg.sv =====
// Result register stage of the FLV tag stream splitter.
// Depends on fts_pkg for the result transaction struct.
module fts_out_reg import fts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/fts_checker.sv =====
// Port-level checker for the FLV tag stream splitter, bound to the top level.
// Depends on fts_pkg for the transaction structs and kind codes.
module fts_checker import fts_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled input transaction keeps its value until taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while stalled");

    // A stalled result keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // The error flag only ever rides on a dropped byte with no markers.
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_flag |->
            o_out_data.unit_kind == K_NONE && !o_out_data.unit_start &&
            !o_out_data.unit_end)
        else $error("error flag on a labeled byte");

    // Unit markers belong to header or tag bytes only.
    a_marker_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.unit_start || o_out_data.unit_end) |->
            o_out_data.unit_kind == K_HEADER || o_out_data.unit_kind == K_META ||
            o_out_data.unit_kind == K_MEDIA)
        else $error("unit marker on trailer or dropped byte");

    // No result is presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind flv_tag_stream_splitter fts_checker u_fts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
